// ===== rtl/b64lw_pkg.sv =====
// Package for the line-wrapping base64 encoder.
// Holds the shared command type, character codes and the symbol table.
// Standalone: depends on nothing.
package b64lw_pkg;

    localparam int LINE_CHARS_DEF  = 68;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int LC_W            = 7;
    localparam int INDENT_W        = 5;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_LOWER = 8'h61;
    localparam logic [7:0] CH_DIGIT = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    // One command per accepted byte: everything the back end must emit.
    typedef struct packed {
        logic       wrap;      // emit a line start first
        logic       nl;        // line start includes a newline
        logic [5:0] sym0;
        logic [5:0] sym1;
        logic       two_sym;
        logic [1:0] npad;
        logic       last;
    } cmd_t;

    typedef enum logic [2:0] {
        SQ_START,
        SQ_NL,
        SQ_SPACE,
        SQ_SYM0,
        SQ_SYM1,
        SQ_PAD
    } seq_t;

    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26)
            r = CH_UPPER + {2'b00, v};
        else if (v < 6'd52)
            r = CH_LOWER + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            r = CH_DIGIT + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            r = CH_PLUS;
        else
            r = CH_SLASH;
        return r;
    endfunction

endpackage

// ===== rtl/b64lw_front.sv =====
// Front end: accepts message bytes, tracks group phase and line fill,
// and turns each byte into one command. Depends on b64lw_pkg.
module b64lw_front #(
    parameter int LINE_CHARS = b64lw_pkg::LINE_CHARS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic               q_full,
    output logic               q_push,
    output b64lw_pkg::cmd_t    q_cmd
);

    localparam logic [b64lw_pkg::LC_W-1:0] LIMIT = b64lw_pkg::LC_W'(LINE_CHARS);

    logic [1:0]                   phase_reg, phase_next;
    logic [3:0]                   carry_reg, carry_next;
    logic [b64lw_pkg::LC_W-1:0]   line_reg, line_next;
    logic                         wrap_reg, wrap_next;
    logic                         started_reg, started_next;

    logic [b64lw_pkg::LC_W-1:0]   lc1, lc2;
    logic                         wrap1, wrap2;
    logic                         accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    // Line fill after the first and second counted symbol.
    always_comb
    begin
        lc1   = line_reg + 1'b1;
        wrap1 = 1'b0;
        if (lc1 >= LIMIT)
        begin
            lc1   = '0;
            wrap1 = 1'b1;
        end
        lc2   = lc1 + 1'b1;
        wrap2 = 1'b0;
        if (lc2 >= LIMIT)
        begin
            lc2   = '0;
            wrap2 = 1'b1;
        end
    end

    always_comb
    begin
        q_cmd.wrap    = wrap_reg;
        q_cmd.nl      = wrap_reg && started_reg;
        q_cmd.last    = last_byte;
        q_cmd.sym1    = '0;
        q_cmd.two_sym = 1'b0;
        q_cmd.npad    = 2'd0;
        phase_next    = phase_reg;
        carry_next    = carry_reg;
        line_next     = lc1;
        wrap_next     = 1'b0;
        started_next  = 1'b1;
        unique case (phase_reg)
            b64lw_pkg::PHASE_1:
            begin
                q_cmd.sym0 = {carry_reg[1:0], data_byte[7:4]};
                carry_next = data_byte[3:0];
                phase_next = b64lw_pkg::PHASE_2;
                wrap_next  = wrap1;
                if (last_byte)
                begin
                    q_cmd.sym1    = {data_byte[3:0], 2'b00};
                    q_cmd.two_sym = 1'b1;
                    q_cmd.npad    = 2'd1;
                end
            end
            b64lw_pkg::PHASE_2:
            begin
                q_cmd.sym0    = {carry_reg, data_byte[7:6]};
                q_cmd.sym1    = data_byte[5:0];
                q_cmd.two_sym = 1'b1;
                carry_next    = '0;
                phase_next    = b64lw_pkg::PHASE_0;
                line_next     = lc2;
                wrap_next     = wrap1 || wrap2;
            end
            default:
            begin
                q_cmd.sym0 = data_byte[7:2];
                carry_next = {2'b00, data_byte[1:0]};
                phase_next = b64lw_pkg::PHASE_1;
                wrap_next  = wrap1;
                if (last_byte)
                begin
                    q_cmd.sym1    = {data_byte[1:0], 4'b0000};
                    q_cmd.two_sym = 1'b1;
                    q_cmd.npad    = 2'd2;
                end
            end
        endcase
        if (last_byte)
        begin
            phase_next   = b64lw_pkg::PHASE_0;
            carry_next   = '0;
            line_next    = '0;
            wrap_next    = 1'b1;
            started_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= b64lw_pkg::PHASE_0;
            carry_reg   <= '0;
            line_reg    <= '0;
            wrap_reg    <= 1'b1;
            started_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            carry_reg   <= carry_next;
            line_reg    <= line_next;
            wrap_reg    <= wrap_next;
            started_reg <= started_next;
        end
    end

endmodule

// ===== rtl/b64lw_queue.sv =====
// Short command queue between front and back end.
// Register-based FIFO of b64lw_pkg::cmd_t entries.
module b64lw_queue #(
    parameter int DEPTH = b64lw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64lw_pkg::cmd_t  push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output b64lw_pkg::cmd_t  head_cmd
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64lw_pkg::cmd_t  mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/b64lw_back.sv =====
// Back end: expands the head command into characters, one per cycle while the output is not stalled,
// into a registered output stage. Depends on b64lw_pkg.
module b64lw_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             head_valid,
    input  b64lw_pkg::cmd_t                  head_cmd,
    output logic                             pop,
    input  logic [b64lw_pkg::INDENT_W-1:0]   indent,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       out_char,
    output logic                             end_of_text
);

    b64lw_pkg::seq_t                  seq_reg, seq_next, step, step_after;
    logic [b64lw_pkg::INDENT_W-1:0]   cnt_reg, cnt_next, cnt, cnt_after, cnt_inc;
    logic                             done;
    logic                             load;
    logic [7:0]                       char_now;

    logic                             out_valid_reg;
    logic [7:0]                       out_char_reg;
    logic                             eot_reg;

    assign load        = head_valid && (!out_valid_reg || !out_stall);
    assign pop         = load && done;
    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign end_of_text = eot_reg;

    // Resolve the first step of a fresh command.
    always_comb
    begin
        if (seq_reg == b64lw_pkg::SQ_START)
        begin
            cnt = '0;
            if (head_cmd.wrap && head_cmd.nl)
                step = b64lw_pkg::SQ_NL;
            else if (head_cmd.wrap && indent != '0)
                step = b64lw_pkg::SQ_SPACE;
            else
                step = b64lw_pkg::SQ_SYM0;
        end
        else
        begin
            cnt  = cnt_reg;
            step = seq_reg;
        end
        cnt_inc = cnt + 1'b1;
    end

    // Step sequencing.
    always_comb
    begin
        step_after = b64lw_pkg::SQ_START;
        cnt_after  = '0;
        done       = 1'b0;
        unique case (step)
            b64lw_pkg::SQ_NL:
                step_after = (indent != '0) ? b64lw_pkg::SQ_SPACE : b64lw_pkg::SQ_SYM0;
            b64lw_pkg::SQ_SPACE:
            begin
                if (cnt_inc == indent)
                    step_after = b64lw_pkg::SQ_SYM0;
                else
                begin
                    step_after = b64lw_pkg::SQ_SPACE;
                    cnt_after  = cnt_inc;
                end
            end
            b64lw_pkg::SQ_SYM0:
            begin
                if (head_cmd.two_sym)
                    step_after = b64lw_pkg::SQ_SYM1;
                else
                    done = 1'b1;
            end
            b64lw_pkg::SQ_SYM1:
            begin
                if (head_cmd.npad != 2'd0)
                    step_after = b64lw_pkg::SQ_PAD;
                else
                    done = 1'b1;
            end
            b64lw_pkg::SQ_PAD:
            begin
                if (cnt_inc == {3'b000, head_cmd.npad})
                    done = 1'b1;
                else
                begin
                    step_after = b64lw_pkg::SQ_PAD;
                    cnt_after  = cnt_inc;
                end
            end
            default:
                done = 1'b1;
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            seq_next = done ? b64lw_pkg::SQ_START : step_after;
            cnt_next = cnt_after;
        end
        else
        begin
            seq_next = seq_reg;
            cnt_next = cnt_reg;
        end
    end

    // Character for the current step.
    always_comb
    begin
        unique case (step)
            b64lw_pkg::SQ_NL:    char_now = b64lw_pkg::CH_NL;
            b64lw_pkg::SQ_SPACE: char_now = b64lw_pkg::CH_SPACE;
            b64lw_pkg::SQ_SYM0:  char_now = b64lw_pkg::b64_sym(head_cmd.sym0);
            b64lw_pkg::SQ_SYM1:  char_now = b64lw_pkg::b64_sym(head_cmd.sym1);
            b64lw_pkg::SQ_PAD:   char_now = b64lw_pkg::CH_PAD;
            default:             char_now = b64lw_pkg::CH_PAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= b64lw_pkg::SQ_START;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg <= seq_next;
            cnt_reg <= cnt_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= char_now;
            eot_reg      <= done && head_cmd.last;
        end
    end

endmodule

// ===== rtl/base64_encoder_line_wrap.sv =====
// Top level of the line-wrapping base64 encoder.
// Instantiates b64lw_front, b64lw_queue and b64lw_back; uses b64lw_pkg.
//
// Streams message bytes (last_byte flags the final one) out as standard
// base64 characters, one character per transfer on the output channel.
// Every line opens with indent_spaces spaces, and every line after the
// first with a newline before them; after LINE_CHARS data symbols the next
// byte starts a new line. The last byte completes the group with '='
// padding where the group needs it, and its final character carries
// end_of_text. Byte transfers complete while the command queue
// (QUEUE_DEPTH entries) has room; the output sequencer then emits one
// character per cycle while out_stall is low: newline and indent spaces
// at each line start, then the byte's one or two symbols, and on the last
// byte any tail symbol and padding. The output register refills as soon as
// it is taken, so characters stream while the receiver does not stall.
// indent_spaces is register 0 of the APB port (byte address 0, 5 bits);
// change it only while the encoder is idle.
module base64_encoder_line_wrap #(
    parameter int LINE_CHARS  = b64lw_pkg::LINE_CHARS_DEF,
    parameter int QUEUE_DEPTH = b64lw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    // character output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        end_of_text,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [b64lw_pkg::INDENT_W-1:0] indent_reg;
    logic                           cfg_hit;

    logic             q_push, q_full, q_pop, q_head_valid;
    b64lw_pkg::cmd_t  q_push_cmd, q_head_cmd;

    // Register 0 sits at byte address 0; paddr[2] set selects nothing.
    assign cfg_hit = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? {{(32 - b64lw_pkg::INDENT_W){1'b0}}, indent_reg} : 32'd0;

    // Write the indent on the access cycle of an APB write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            indent_reg <= '0;
        else if (psel && penable && pwrite && cfg_hit)
            indent_reg <= pwdata[b64lw_pkg::INDENT_W-1:0];
    end

    // Front: classify each byte into a command and track line fill.
    b64lw_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    // Queue: decouple byte intake from character output.
    b64lw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // Back: emit newline, indent, symbols and padding one per cycle while the output is not stalled.
    b64lw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head_cmd    (q_head_cmd),
        .pop         (q_pop),
        .indent      (indent_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .end_of_text (end_of_text)
    );

endmodule

// ===== tb/b64lw_char_checker.sv =====
// Character checker for the line-wrapping base64 encoder testbench.
// Watches the byte, character and APB channels, predicts every character and compares.
// Depends on b64lw_pkg for the character codes, phase codes and line length.
module b64lw_char_checker #(
    parameter logic [2:0] INDENT_ADDR = 3'd0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_char,
    input  logic        end_of_text,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          chars_pending,
    output int          error_cnt,
    output int          bytes_seen,
    output int          msgs_seen,
    output int          chars_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } enc_char_t;

    enc_char_t  expected_chars[$];

    // predictor state
    logic [1:0] grp_phase;
    logic [3:0] carry;
    logic [6:0] line_cnt;
    logic       wrap_due;
    logic       msg_open;
    logic [4:0] indent;

    int         n_err;
    int         n_bytes;
    int         n_msgs;
    int         n_chars;

    function automatic logic [7:0] sym_of(input logic [5:0] v);
        return B64_ALPHABET[8 * (63 - int'(v)) +: 8];
    endfunction

    task automatic queue_char(input logic [7:0] ch);
        enc_char_t e;
        e.ch  = ch;
        e.eot = 1'b0;
        expected_chars.push_back(e);
    endtask

    // Data symbols advance the line; tail symbols never do.
    task automatic queue_symbol(input logic [5:0] v, input logic counts);
        queue_char(sym_of(v));
        if (counts)
        begin
            line_cnt = line_cnt + 7'd1;
            if (int'(line_cnt) >= b64lw_pkg::LINE_CHARS_DEF)
            begin
                line_cnt = '0;
                wrap_due = 1'b1;
            end
        end
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic fin);
        enc_char_t tail;
        int        k;
        if (wrap_due)
        begin
            if (msg_open)
                queue_char(b64lw_pkg::CH_NL);
            for (k = 0; k < int'(indent); k++)
                queue_char(b64lw_pkg::CH_SPACE);
            wrap_due = 1'b0;
        end
        msg_open = 1'b1;
        case (grp_phase)
            b64lw_pkg::PHASE_1:
            begin
                queue_symbol({carry[1:0], b[7:4]}, 1'b1);
                carry     = b[3:0];
                grp_phase = b64lw_pkg::PHASE_2;
                if (fin)
                begin
                    queue_symbol({carry, 2'b00}, 1'b0);
                    queue_char(b64lw_pkg::CH_PAD);
                end
            end
            b64lw_pkg::PHASE_2:
            begin
                queue_symbol({carry, b[7:6]}, 1'b1);
                queue_symbol(b[5:0], 1'b1);
                carry     = '0;
                grp_phase = b64lw_pkg::PHASE_0;
            end
            default:
            begin
                // phase 3 cannot occur; it falls in here like phase 0
                queue_symbol(b[7:2], 1'b1);
                carry     = {2'b00, b[1:0]};
                grp_phase = b64lw_pkg::PHASE_1;
                if (fin)
                begin
                    queue_symbol({carry[1:0], 4'b0000}, 1'b0);
                    queue_char(b64lw_pkg::CH_PAD);
                    queue_char(b64lw_pkg::CH_PAD);
                end
            end
        endcase
        if (fin)
        begin
            // flag the final character, then start over for the next message
            tail     = expected_chars.pop_back();
            tail.eot = 1'b1;
            expected_chars.push_back(tail);
            grp_phase = b64lw_pkg::PHASE_0;
            carry     = '0;
            line_cnt  = '0;
            wrap_due  = 1'b1;
            msg_open  = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        enc_char_t want;
        if (!rst_n)
        begin
            expected_chars.delete();
            grp_phase     = b64lw_pkg::PHASE_0;
            carry         = '0;
            line_cnt      = '0;
            wrap_due      = 1'b1;
            msg_open      = 1'b0;
            indent        = '0;
            n_err         = 0;
            n_bytes       = 0;
            n_msgs        = 0;
            n_chars       = 0;
            chars_pending <= 0;
            error_cnt     <= 0;
            bytes_seen    <= 0;
            msgs_seen     <= 0;
            chars_seen    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_chars++;
                if (expected_chars.size() == 0)
                begin
                    n_err++;
                    $display("%0t char checker: unexpected char %02h eot %0b",
                             $time, out_char, end_of_text);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (want.ch !== out_char || want.eot !== end_of_text)
                    begin
                        n_err++;
                        $display("%0t char checker: expected %02h eot %0b, got %02h eot %0b",
                                 $time, want.ch, want.eot, out_char, end_of_text);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                encode_byte(data_byte, last_byte);
                n_bytes++;
                if (last_byte)
                    n_msgs++;
            end
            if (psel && penable && pwrite && pready && paddr == INDENT_ADDR)
                indent = pwdata[4:0];
            chars_pending <= expected_chars.size();
            error_cnt     <= n_err;
            bytes_seen    <= n_bytes;
            msgs_seen     <= n_msgs;
            chars_seen    <= n_chars;
        end
    end

endmodule

// ===== tb/tb_base64_encoder_line_wrap.sv =====
// Top of the testbench for base64_encoder_line_wrap: clock, reset, stimulus and verdict.
// Needs the encoder RTL, b64lw_pkg and b64lw_char_checker, which does all predicting.
module tb_base64_encoder_line_wrap;
    timeunit 1ns;
    timeprecision 1ps;

    // register map: indent at index 0, index 1 has no register behind it
    localparam logic [2:0] ADDR_INDENT = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    // cycles without any transfer before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // quiet cycles after draining, to catch stray characters
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_BYTES    = 56;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_char;
    logic        end_of_text;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int chars_pending;
    int error_cnt;
    int bytes_seen;
    int msgs_seen;
    int chars_seen;

    // percentage of cycles the byte sender idles / the char receiver stalls
    int send_pct  = 0;
    int stall_pct = 0;
    int watchdog_cnt = 0;

    base64_encoder_line_wrap i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .end_of_text (end_of_text),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    b64lw_char_checker #(
        .INDENT_ADDR (ADDR_INDENT)
    ) i_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_char      (out_char),
        .end_of_text   (end_of_text),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .chars_pending (chars_pending),
        .error_cnt     (error_cnt),
        .bytes_seen    (bytes_seen),
        .msgs_seen     (msgs_seen),
        .chars_seen    (chars_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver back-pressure: stall a random share of cycles, independent of valid.
    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);

    // Watchdog: count cycles with no transfer on any channel; a hung run ends here.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            watchdog_cnt <= 0;
        else
            watchdog_cnt <= watchdog_cnt + 1;
        if (watchdog_cnt >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog expired with %0d chars outstanding", $time, chars_pending);
            $display("tb_base64_encoder_line_wrap: done, errors");
            $finish;
        end
    end

    // APB write: setup cycle, access cycle, then an idle step with psel low so
    // that two writes in a row never drop and raise psel in the same step.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one byte, idling first at the phase's rate, and return at the
    // edge that completed the transfer. Valid stays high into the next call
    // when no gap follows, so back-to-back bytes never see a glitch.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (send_pct != 0 && $urandom_range(99, 0) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_message(input int len);
        int i;
        for (i = 0; i < len; i++)
            send_byte(8'($urandom_range(255, 0)), i == len - 1);
    endtask

    // Drop valid and hold until every predicted character has come out, then
    // stay quiet a while so that a stray extra character gets caught before
    // the register is touched again.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (chars_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int p;
        int len;
        int phase_bytes;
        logic [31:0] indent_val;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: group tails with two, one and no pad, every symbol extreme.
        reg_write(ADDR_INDENT, 32'd0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        // '+' and '/' alternate in this group
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b1);
        wait_drained();

        // Widest line start: 31 spaces ahead of a one-byte message.
        reg_write(ADDR_INDENT, 32'd31);
        send_byte(8'h5A, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);
        wait_drained();

        // A write past the only register must leave the indent alone.
        reg_write(ADDR_UNUSED, $urandom());
        send_byte(8'hA5, 1'b1);
        wait_drained();

        // Random phases: cycle the idle patterns and sweep the indent,
        // extremes included. Each phase opens with a long message, which
        // mostly crosses a line wrap; the phase's byte budget caps lengths.
        for (p = 0; p < 6; p++)
        begin
            case (p)
                0:       indent_val = 32'd0;
                1:       indent_val = 32'd31;
                3:       indent_val = 32'd1;
                5:       indent_val = 32'hFFFF_FFFF;
                default: indent_val = $urandom();
            endcase
            reg_write(ADDR_INDENT, indent_val);
            case (p % 4)
                0:
                begin
                    send_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_pct  = 74;
                    stall_pct = 0;
                end
                2:
                begin
                    send_pct  = 0;
                    stall_pct = 74;
                end
                default:
                begin
                    send_pct  = 7;
                    stall_pct = 7;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                if (phase_bytes == 0 || $urandom_range(3, 0) == 0)
                    len = $urandom_range(140, 45);
                else
                    len = $urandom_range(12, 1);
                if (len > PHASE_BYTES - phase_bytes)
                    len = PHASE_BYTES - phase_bytes;
                send_message(len);
                phase_bytes += len;
            end
            wait_drained();
        end

        send_pct  = 0;
        stall_pct = 0;
        wait_drained();

        $display("covered %0d bytes in %0d messages, %0d characters compared,",
                 bytes_seen, msgs_seen, chars_seen);
        $display("indent 0 to 31 under four idle and stall patterns, %0d mismatches",
                 error_cnt);
        if (error_cnt == 0)
            $display("tb_base64_encoder_line_wrap: done, clean");
        else
            $display("tb_base64_encoder_line_wrap: done, errors");
        $finish;
    end

endmodule
